>>> hdl/sevm_pkg.sv
// Shared types, constants and helpers for the sphere environment map UV block.
// Used by sevm_coord and sphere_env_map_uv; no dependencies.
package sevm_pkg;

    localparam int CFG_W   = 60;
    localparam int COEF_W  = 20;
    localparam int CIDX_W  = 3;
    localparam int TEX_W   = 16;

    // Coordinate lane widths: squared component, squared length, quotient
    localparam int C2_W    = 31;
    localparam int LEN_W   = 32;
    localparam int QUO_W   = 31;

    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = TEX_W;
    localparam int LANE_LAT   = DIV_STEPS + SQRT_STEPS + 1;

    localparam logic [TEX_W-1:0] TEX_MID = 16'h8000;
    localparam logic [TEX_W-1:0] TEX_MAX = 16'hFFFF;

    // Reset rows: 1.0 in Q4.16, column 1 for row 0, column 0 for rows 1 and 2
    localparam logic [CFG_W-1:0] ROW0_RST = 60'h000_0010_0000_0000;
    localparam logic [CFG_W-1:0] ROW1_RST = 60'h000_0000_0001_0000;
    localparam logic [CFG_W-1:0] ROW2_RST = 60'h000_0000_0001_0000;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MODEL0  = 3'd0,
        CFG_MODEL1  = 3'd1,
        CFG_MODEL2  = 3'd2,
        CFG_NORMAL0 = 3'd3,
        CFG_NORMAL1 = 3'd4,
        CFG_NORMAL2 = 3'd5,
        CFG_CAMERA  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               last_vertex;
    } t_in_beat;

    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             degenerate;
        logic             last_out;
    } t_out_beat;

    typedef struct packed {
        logic vld;
        logic last;
        logic deg;
    } t_side;

    function automatic logic signed [COEF_W-1:0] f_coef(input logic [CFG_W-1:0] row,
                                                         input int j);
        f_coef = $signed(row[COEF_W*j +: COEF_W]);
    endfunction

endpackage

>>> hdl/sphere_env_map_uv.sv
// Top level of the sphere environment map UV pipeline: config registers,
// transform, reflect and normalize stages. Depends on sevm_pkg and sevm_coord.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------
//  vertex   | i_in_valid  / o_in_stall     | i_in_data   (t_in_beat)
//  texcoord | o_out_valid / i_out_stall    | o_out_data  (t_out_beat)
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One vertex per cycle unless the output stalls; 14 vector stages, then a 31-stage
// divider and a 16-stage square root per coordinate lane, then the output register.
// Reset (synchronous) empties the pipeline and loads the reset matrices, camera zero.
// A stalled output beat freezes the whole pipeline and stalls the vertex channel.
// Config writes are taken every cycle.
module sphere_env_map_uv import sevm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int TOP_STAGES = 14;
    localparam int TOTAL      = TOP_STAGES + LANE_LAT;
    localparam int WIDE_W     = 51;
    localparam int SH_W       = 6;

    function automatic logic [WIDE_W-1:0] f_mag(input logic signed [WIDE_W-1:0] x);
        f_mag = x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
    endfunction

    // Smallest shift that brings the magnitude below 2^15
    function automatic logic [SH_W-1:0] f_shamt(input logic [WIDE_W-1:0] m);
        logic [SH_W-1:0] sh;
        sh = '0;
        for (int i = 15; i < WIDE_W; i++) begin
            if (m[i]) begin
                sh = SH_W'(i - 14);
            end
        end
        f_shamt = sh;
    endfunction

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_model  [3];
    logic [CFG_W-1:0] r_normal [3];
    logic [CFG_W-1:0] r_cam;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model[0]  <= ROW0_RST;
            r_model[1]  <= ROW1_RST;
            r_model[2]  <= ROW2_RST;
            r_normal[0] <= ROW0_RST;
            r_normal[1] <= ROW1_RST;
            r_normal[2] <= ROW2_RST;
            r_cam       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODEL0:  r_model[0]  <= i_cfg_data;
                CFG_MODEL1:  r_model[1]  <= i_cfg_data;
                CFG_MODEL2:  r_model[2]  <= i_cfg_data;
                CFG_NORMAL0: r_normal[0] <= i_cfg_data;
                CFG_NORMAL1: r_normal[1] <= i_cfg_data;
                CFG_NORMAL2: r_normal[2] <= i_cfg_data;
                CFG_CAMERA:  r_cam       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic  w_en;
    t_side r_sd [TOTAL];
    t_side n_sd [TOTAL];

    assign w_en       = !(r_sd[TOTAL-1].vld && i_out_stall);
    assign o_in_stall = !w_en;

    // ---------------- datapath registers ----------------
    logic signed [15:0] w_nin [3];
    logic signed [23:0] w_pin [3];

    logic signed [35:0] r1_np [3][3];
    logic signed [43:0] r1_vp [3][3];
    logic signed [37:0] r2_n [3];
    logic signed [46:0] r2_v [3];
    logic signed [37:0] r3_n [3];
    logic signed [46:0] r3_v [3];
    logic [WIDE_W-1:0]  r3_nor;
    logic [WIDE_W-1:0]  r3_vor;
    logic signed [37:0] r4_n [3];
    logic signed [46:0] r4_v [3];
    logic [SH_W-1:0]    r4_ns;
    logic [SH_W-1:0]    r4_vs;
    logic signed [15:0] r5_n [3];
    logic signed [15:0] r5_v [3];
    logic signed [31:0] r6_nv [3];
    logic signed [31:0] r6_nn [3];
    logic signed [15:0] r6_n [3];
    logic signed [15:0] r6_v [3];
    logic signed [33:0] r7_dot;
    logic signed [32:0] r7_nn;
    logic signed [15:0] r7_n [3];
    logic signed [15:0] r7_v [3];
    logic signed [49:0] r8_a [3];
    logic signed [48:0] r8_b [3];
    logic signed [WIDE_W-1:0] r9_r [3];
    logic signed [WIDE_W-1:0] r10_r [3];
    logic [WIDE_W-1:0]  r10_ror;
    logic signed [WIDE_W-1:0] r11_r [3];
    logic [SH_W-1:0]    r11_rs;
    logic signed [15:0] r12_r [3];
    logic [C2_W-1:0]    r13_sq [3];
    logic               r13_nx;
    logic               r13_ny;
    logic [LEN_W-1:0]   r14_len;
    logic [C2_W-1:0]    r14_c2x;
    logic [C2_W-1:0]    r14_c2y;
    logic               r14_nx;
    logic               r14_ny;

    assign w_nin[0] = i_in_data.norm_x;
    assign w_nin[1] = i_in_data.norm_y;
    assign w_nin[2] = i_in_data.norm_z;
    assign w_pin[0] = i_in_data.pos_x;
    assign w_pin[1] = i_in_data.pos_y;
    assign w_pin[2] = i_in_data.pos_z;

    logic w_nzero;
    logic w_rzero;
    assign w_nzero = (r2_n[0] == '0) && (r2_n[1] == '0) && (r2_n[2] == '0);
    assign w_rzero = (r9_r[0] == '0) && (r9_r[1] == '0) && (r9_r[2] == '0);

    // Side-band: valid, last mark and degenerate flag travel with the data
    always_comb begin
        n_sd[0].vld  = i_in_valid;
        n_sd[0].last = i_in_data.last_vertex;
        n_sd[0].deg  = 1'b0;
        for (int k = 1; k < TOTAL; k++) begin
            n_sd[k] = r_sd[k-1];
        end
        n_sd[2].deg = w_nzero;
        n_sd[9].deg = r_sd[8].deg || w_rzero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOTAL; k++) begin
                r_sd[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            for (int k = 0; k < TOTAL; k++) begin
                r_sd[k] <= n_sd[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1: matrix products
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r1_np[i][j] <= w_nin[i] * f_coef(r_normal[i], j);
                    r1_vp[i][j] <= w_pin[i] * f_coef(r_model[i], j);
                end
            end
            for (int j = 0; j < 3; j++) begin
                // stage 2: row sums, camera removed
                r2_n[j] <= 38'(r1_np[0][j]) + 38'(r1_np[1][j]) + 38'(r1_np[2][j]);
                r2_v[j] <= 47'(r1_vp[0][j]) + 47'(r1_vp[1][j]) + 47'(r1_vp[2][j])
                         - (47'(f_coef(r_cam, j)) <<< 16);
                // stage 3
                r3_n[j] <= r2_n[j];
                r3_v[j] <= r2_v[j];
                // stage 4
                r4_n[j] <= r3_n[j];
                r4_v[j] <= r3_v[j];
                // stage 5: block scale to 16 bits
                r5_n[j] <= 16'(r4_n[j] >>> r4_ns);
                r5_v[j] <= 16'(r4_v[j] >>> r4_vs);
                // stage 6
                r6_nv[j] <= r5_n[j] * r5_v[j];
                r6_nn[j] <= r5_n[j] * r5_n[j];
                r6_n[j]  <= r5_n[j];
                r6_v[j]  <= r5_v[j];
                // stage 7
                r7_n[j] <= r6_n[j];
                r7_v[j] <= r6_v[j];
                // stage 8
                r8_a[j] <= r7_n[j] * r7_dot;
                r8_b[j] <= r7_v[j] * r7_nn;
                // stage 9: unnormalized reflection
                r9_r[j] <= (WIDE_W'(r8_a[j]) <<< 1) - WIDE_W'(r8_b[j]);
                // stage 10, 11
                r10_r[j] <= r9_r[j];
                r11_r[j] <= r10_r[j];
                // stage 12
                r12_r[j] <= 16'(r11_r[j] >>> r11_rs);
                // stage 13
                r13_sq[j] <= C2_W'(r12_r[j] * r12_r[j]);
            end
            r3_nor  <= f_mag(WIDE_W'(r2_n[0])) | f_mag(WIDE_W'(r2_n[1]))
                     | f_mag(WIDE_W'(r2_n[2]));
            r3_vor  <= f_mag(WIDE_W'(r2_v[0])) | f_mag(WIDE_W'(r2_v[1]))
                     | f_mag(WIDE_W'(r2_v[2]));
            r4_ns   <= f_shamt(r3_nor);
            r4_vs   <= f_shamt(r3_vor);
            r7_dot  <= 34'(r6_nv[0]) + 34'(r6_nv[1]) + 34'(r6_nv[2]);
            r7_nn   <= 33'(r6_nn[0]) + 33'(r6_nn[1]) + 33'(r6_nn[2]);
            r10_ror <= f_mag(r9_r[0]) | f_mag(r9_r[1]) | f_mag(r9_r[2]);
            r11_rs  <= f_shamt(r10_ror);
            r13_nx  <= r12_r[0][15];
            r13_ny  <= r12_r[1][15];
            // stage 14: squared length
            r14_len <= LEN_W'(r13_sq[0]) + LEN_W'(r13_sq[1]) + LEN_W'(r13_sq[2]);
            r14_c2x <= r13_sq[0];
            r14_c2y <= r13_sq[1];
            r14_nx  <= r13_nx;
            r14_ny  <= r13_ny;
        end
    end

    // ---------------- coordinate lanes ----------------
    logic [TEX_W-1:0] w_tex_u;
    logic [TEX_W-1:0] w_tex_v;

    sevm_coord u_lane_u (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_c2   (r14_c2x),
        .i_len2 (r14_len),
        .i_neg  (r14_nx),
        .o_tex  (w_tex_u)
    );

    sevm_coord u_lane_v (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_c2   (r14_c2y),
        .i_len2 (r14_len),
        .i_neg  (r14_ny),
        .o_tex  (w_tex_v)
    );

    assign o_out_valid           = r_sd[TOTAL-1].vld;
    assign o_out_data.tex_u      = r_sd[TOTAL-1].deg ? TEX_MID : w_tex_u;
    assign o_out_data.tex_v      = r_sd[TOTAL-1].deg ? TEX_MID : w_tex_v;
    assign o_out_data.degenerate = r_sd[TOTAL-1].deg;
    assign o_out_data.last_out   = r_sd[TOTAL-1].last;

`ifndef SYNTH
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held output beat");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_scaled_r_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sd[11].vld && !r_sd[11].deg) |->
        ((r12_r[0] != '0) || (r12_r[1] != '0) || (r12_r[2] != '0)))
        else $error("block scaling zeroed a nonzero reflection");

    a_len_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sd[13].vld && !r_sd[13].deg) |->
        ((r14_len >= LEN_W'(r14_c2x)) && (r14_len >= LEN_W'(r14_c2y))))
        else $error("squared length below a squared component");
`endif

endmodule

>>> hdl/sevm_coord.sv
// One texture coordinate lane: pipelined divide of c^2 * 2^30 by |r|^2, pipelined
// integer square root, then offset and saturate. Depends on sevm_pkg.
module sevm_coord import sevm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [C2_W-1:0]  i_c2,
    input  logic [LEN_W-1:0] i_len2,
    input  logic             i_neg,
    output logic [TEX_W-1:0] o_tex
);

    logic [LEN_W-1:0] r_drem [DIV_STEPS-1];
    logic [LEN_W-1:0] r_dlen [DIV_STEPS-1];
    logic [QUO_W-1:0] r_dquo [DIV_STEPS];
    logic             r_dneg [DIV_STEPS];

    logic [LEN_W-1:0] r_sx   [SQRT_STEPS-1];
    logic [LEN_W-1:0] r_sr   [SQRT_STEPS];
    logic             r_sneg [SQRT_STEPS];

    logic [TEX_W-1:0] r_tex;

    // Restoring division, one quotient bit per stage
    genvar d;
    generate
        for (d = 0; d < DIV_STEPS; d++) begin : g_div
            logic [LEN_W-1:0] w_rem_in;
            logic [LEN_W-1:0] w_len_in;
            logic [QUO_W-1:0] w_quo_in;
            logic             w_bit;
            logic             w_neg_in;
            logic [LEN_W:0]   w_trial;
            logic             w_ge;
            logic [LEN_W-1:0] n_rem;

            if (d == 0) begin : g_first
                // c^2 >> 1 is already below the divisor
                assign w_rem_in = LEN_W'(i_c2 >> 1);
                assign w_len_in = i_len2;
                assign w_quo_in = '0;
                assign w_bit    = i_c2[0];
                assign w_neg_in = i_neg;
            end else begin : g_rest
                assign w_rem_in = r_drem[d-1];
                assign w_len_in = r_dlen[d-1];
                assign w_quo_in = r_dquo[d-1];
                assign w_bit    = 1'b0;
                assign w_neg_in = r_dneg[d-1];
            end

            assign w_trial = {w_rem_in, w_bit};
            assign w_ge    = (w_trial >= {1'b0, w_len_in});
            assign n_rem   = w_ge ? LEN_W'(w_trial - {1'b0, w_len_in}) : LEN_W'(w_trial);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dquo[d] <= {w_quo_in[QUO_W-2:0], w_ge};
                    r_dneg[d] <= w_neg_in;
                end
            end

            if (d < DIV_STEPS - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_drem[d] <= n_rem;
                        r_dlen[d] <= w_len_in;
                    end
                end
            end
        end
    endgenerate

    // Digit-by-digit square root, one result bit per stage
    genvar s;
    generate
        for (s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
            localparam logic [LEN_W-1:0] BIT = LEN_W'(1) << (2 * (SQRT_STEPS - 1 - s));
            logic [LEN_W-1:0] w_x_in;
            logic [LEN_W-1:0] w_r_in;
            logic             w_neg_in;
            logic [LEN_W-1:0] w_sum;
            logic             w_ge;

            if (s == 0) begin : g_first
                assign w_x_in   = LEN_W'(r_dquo[DIV_STEPS-1]);
                assign w_r_in   = '0;
                assign w_neg_in = r_dneg[DIV_STEPS-1];
            end else begin : g_rest
                assign w_x_in   = r_sx[s-1];
                assign w_r_in   = r_sr[s-1];
                assign w_neg_in = r_sneg[s-1];
            end

            assign w_sum = w_r_in + BIT;
            assign w_ge  = (w_x_in >= w_sum);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sr[s]   <= w_ge ? (w_r_in >> 1) + BIT : (w_r_in >> 1);
                    r_sneg[s] <= w_neg_in;
                end
            end

            if (s < SQRT_STEPS - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_sx[s] <= w_ge ? w_x_in - w_sum : w_x_in;
                    end
                end
            end
        end
    endgenerate

    logic [TEX_W-1:0] w_q;
    logic [TEX_W:0]   w_t;
    logic [TEX_W-1:0] n_tex;

    assign w_q   = r_sr[SQRT_STEPS-1][TEX_W-1:0];
    assign w_t   = r_sneg[SQRT_STEPS-1] ? {1'b0, TEX_MID} - {1'b0, w_q}
                                        : {1'b0, TEX_MID} + {1'b0, w_q};
    // Clamp +1.0 to the top code
    assign n_tex = w_t[TEX_W] ? TEX_MAX : w_t[TEX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tex <= n_tex;
        end
    end

    assign o_tex = r_tex;

endmodule
